// File: design/hpg_pkg.sv
// hpg_pkg: shared types, codes and constants of the hex path generator
// no dependencies
`default_nettype none

package hpg_pkg;

	localparam int COORD_BITS      = 12;
	localparam int MAX_POINTS_DEF  = 64;
	localparam int RING_MAX_DEF    = 10;
	localparam int RADIUS_BITS     = 4;
	localparam int PADDR_BITS      = 3;

	localparam logic [1:0] MODE_LINE  = 2'd0;
	localparam logic [1:0] MODE_RING  = 2'd1;
	localparam logic [1:0] MODE_LPATH = 2'd2;
	localparam logic [1:0] MODE_NOP   = 2'd3;

	localparam logic [7:0] GLYPH_LINE  = 8'd42;
	localparam logic [7:0] GLYPH_RING  = 8'd111;
	localparam logic [7:0] GLYPH_LPATH = 8'd43;

	localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 4'd3;
	localparam logic [PADDR_BITS-1:0]  ADDR_RING_RADIUS = 3'd0;

	typedef struct packed {
		logic [1:0]                   mode;
		logic                         start_set;
		logic signed [COORD_BITS-1:0] start_q;
		logic signed [COORD_BITS-1:0] start_r;
		logic signed [COORD_BITS-1:0] end_q;
		logic signed [COORD_BITS-1:0] end_r;
		logic signed [COORD_BITS-1:0] center_q;
		logic signed [COORD_BITS-1:0] center_r;
	} in_word_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] hex_q;
		logic signed [COORD_BITS-1:0] hex_r;
		logic [7:0]                   glyph;
		logic                         last;
		logic                         truncated;
	} out_word_t;

	typedef struct packed {
		logic load;
		logic step;
	} dp_cmd_t;

	typedef struct packed {
		logic last;
	} dp_stat_t;

endpackage

`default_nettype wire

// File: design/hex_path_generator_top.sv
// hex_path_generator_top: top level, register port plus controller and datapath
// depends on hpg_pkg, hpg_ctrl, hpg_dp
`default_nettype none

// takes one path request word on an axial hex grid and sends out the hexes of
// the path in walk order, one word per cycle while out_stall is low: a line
// draw (distance+1 hexes, exact rounding, ties away from zero), a ring of
// 6*radius hexes starting north-west of the centre (the centre alone for
// radius zero), or an l-shaped walk along q then r. runs longer than
// MAX_POINTS are cut and the last word carries truncated. a request is
// accepted and set up on its load, then the walk counters and the line
// remainder registers step once per emitted hex. a request that emits nothing
// (no-op, or no start pinned) leaves the controller idle. the ring radius
// sits at byte address 0 of the register port, reset value 3, saturated at
// RING_MAX; write it only while idle

module hex_path_generator_top import hpg_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int RING_MAX   = RING_MAX_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// request words
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  in_word_t                   in_word,
	// path hex words
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output out_word_t                  out_word,
	// register port
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [PADDR_BITS-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	logic [RADIUS_BITS-1:0] ring_radius_q;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// register port, always ready
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_RING_RADIUS) ? 32'(ring_radius_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_radius_q <= RADIUS_RESET;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_RING_RADIUS) begin
			ring_radius_q <= pwdata[RADIUS_BITS-1:0];
		end
	end

	// controller: accepts a word and paces one hex per free output slot
	hpg_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_mode      (in_word.mode),
		.in_start_set (in_word.start_set),
		.in_stall     (in_stall),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.stat         (stat),
		.cmd          (cmd)
	);

	// datapath: walk registers, line rounding, output register
	hpg_dp #(
		.MAX_POINTS (MAX_POINTS),
		.RING_MAX   (RING_MAX)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.in_word     (in_word),
		.ring_radius (ring_radius_q),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_word    (out_word)
	);

endmodule

`default_nettype wire

// File: design/hpg_ctrl.sv
// hpg_ctrl: controller of the hex path generator, accepts words and paces the walk
// depends on hpg_pkg
`default_nettype none

module hpg_ctrl import hpg_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [1:0] in_mode,
	input  wire logic       in_start_set,
	output logic            in_stall,
	input  wire logic       out_valid,
	input  wire logic       out_stall,
	input  dp_stat_t        stat,
	output dp_cmd_t         cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic state_q;
	logic accept;
	logic has_work;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		case (in_mode)
			MODE_LINE:  has_work = in_start_set;
			MODE_RING:  has_work = 1'b1;
			MODE_LPATH: has_work = in_start_set;
			default:    has_work = 1'b0;
		endcase
	end

	assign cmd.load = accept;
	assign cmd.step = (state_q == ST_RUN) && (!out_valid || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (accept && has_work) state_q <= ST_RUN;
				ST_RUN:  if (cmd.step && stat.last) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: design/hpg_dp.sv
// hpg_dp: datapath of the hex path generator, walk registers and output register
// depends on hpg_pkg
`default_nettype none

module hpg_dp import hpg_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int RING_MAX   = RING_MAX_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  dp_cmd_t                     cmd,
	input  in_word_t                    in_word,
	input  wire logic [RADIUS_BITS-1:0] ring_radius,
	output dp_stat_t                    stat,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output out_word_t                   out_word
);

	localparam int C  = COORD_BITS;
	localparam int W  = COORD_BITS + 3;
	localparam int CW = $clog2(MAX_POINTS);

	logic [1:0]                 mode_q;
	logic signed [W-1:0]        base_q [3];
	logic signed [W-1:0]        d_q    [3];
	logic signed [W-1:0]        k_q    [3];
	logic signed [W-1:0]        rem_q  [3];
	logic signed [W-1:0]        n_q;
	logic [C-1:0]               pos_q_q, pos_r_q, end_q_q, end_r_q;
	logic                       sq_neg_q, sr_neg_q;
	logic [2:0]                 dir_q;
	logic [RADIUS_BITS-1:0]     j_q, nr_q;
	logic [CW-1:0]              cnt_q;
	logic                       out_valid_q;
	out_word_t                  out_q;

	// load-time arithmetic
	logic signed [W-1:0] l_a [3];
	logic signed [W-1:0] l_d [3];
	logic signed [W-1:0] l_abs [3];
	logic signed [W-1:0] l_n;
	logic [RADIUS_BITS-1:0] l_nr;

	always_comb begin
		l_a[0] = W'(in_word.start_q);
		l_a[1] = W'(in_word.start_r);
		l_a[2] = -l_a[0] - l_a[1];
		l_d[0] = W'(in_word.end_q) - l_a[0];
		l_d[1] = W'(in_word.end_r) - l_a[1];
		l_d[2] = -l_d[0] - l_d[1];
		for (int c = 0; c < 3; c++) begin
			l_abs[c] = l_d[c][W-1] ? -l_d[c] : l_d[c];
		end
		l_n  = (l_abs[0] + l_abs[1] + l_abs[2]) >>> 1;
		l_nr = (ring_radius > RADIUS_BITS'(RING_MAX)) ? RADIUS_BITS'(RING_MAX) : ring_radius;
	end

	// line point rounding and next remainder
	logic signed [W-1:0] b_v [3];
	logic signed [W-1:0] val [3];
	logic signed [W-1:0] err [3];
	logic signed [W-1:0] rsum [3];
	logic signed [W-1:0] k_nx [3];
	logic signed [W-1:0] rem_nx [3];
	logic                up;
	logic [C-1:0]        line_q, line_r;

	always_comb begin
		up = 1'b0;
		for (int c = 0; c < 3; c++) begin
			b_v[c] = base_q[c] + k_q[c];
			if ((rem_q[c] <<< 1) > n_q)      up = 1'b1;
			else if ((rem_q[c] <<< 1) < n_q) up = 1'b0;
			else                             up = !b_v[c][W-1];
			err[c] = up ? (n_q - rem_q[c]) : rem_q[c];
			val[c] = b_v[c] + W'(up);
			rsum[c] = rem_q[c] + d_q[c];
			if (rsum[c] >= n_q) begin
				rem_nx[c] = rsum[c] - n_q;
				k_nx[c]   = k_q[c] + W'(1);
			end else if (rsum[c][W-1]) begin
				rem_nx[c] = rsum[c] + n_q;
				k_nx[c]   = k_q[c] - W'(1);
			end else begin
				rem_nx[c] = rsum[c];
				k_nx[c]   = k_q[c];
			end
		end
		if (n_q == '0) begin
			line_q = base_q[0][C-1:0];
			line_r = base_q[1][C-1:0];
		end else if (err[0] > err[1] && err[0] > err[2]) begin
			line_q = C'(-val[1] - val[2]);
			line_r = val[1][C-1:0];
		end else if (err[1] > err[2]) begin
			line_q = val[0][C-1:0];
			line_r = C'(-val[0] - val[2]);
		end else begin
			line_q = val[0][C-1:0];
			line_r = val[1][C-1:0];
		end
	end

	// ring step directions
	logic [C-1:0] dir_dq, dir_dr;

	always_comb begin
		case (dir_q)
			3'd0:    begin dir_dq = C'(1);  dir_dr = C'(0);  end
			3'd1:    begin dir_dq = C'(0);  dir_dr = C'(1);  end
			3'd2:    begin dir_dq = '1;     dir_dr = C'(1);  end
			3'd3:    begin dir_dq = '1;     dir_dr = C'(0);  end
			3'd4:    begin dir_dq = C'(0);  dir_dr = '1;     end
			default: begin dir_dq = C'(1);  dir_dr = '1;     end
		endcase
	end

	// current point and end of walk
	logic [C-1:0] pt_q, pt_r;
	logic [7:0]   glyph;
	logic         nat_end, cap, ring_turn;

	assign cap       = (cnt_q == CW'(MAX_POINTS - 1));
	assign ring_turn = (j_q == nr_q - RADIUS_BITS'(1));

	always_comb begin
		case (mode_q)
			MODE_LINE: begin
				pt_q = line_q; pt_r = line_r; glyph = GLYPH_LINE;
				nat_end = (W'(cnt_q) == n_q);
			end
			MODE_RING: begin
				pt_q = pos_q_q; pt_r = pos_r_q; glyph = GLYPH_RING;
				nat_end = (nr_q == '0) || (dir_q == 3'd5 && ring_turn);
			end
			default: begin
				pt_q = pos_q_q; pt_r = pos_r_q; glyph = GLYPH_LPATH;
				nat_end = (pos_q_q == end_q_q) && (pos_r_q == end_r_q);
			end
		endcase
	end

	assign stat.last = nat_end || cap;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q   <= in_word.mode;
			n_q      <= l_n;
			cnt_q    <= '0;
			dir_q    <= '0;
			j_q      <= '0;
			nr_q     <= l_nr;
			end_q_q  <= in_word.end_q;
			end_r_q  <= in_word.end_r;
			sq_neg_q <= l_d[0][W-1];
			sr_neg_q <= l_d[1][W-1];
			for (int c = 0; c < 3; c++) begin
				base_q[c] <= l_a[c];
				d_q[c]    <= l_d[c];
				k_q[c]    <= '0;
				rem_q[c]  <= '0;
			end
			if (in_word.mode == MODE_RING) begin
				pos_q_q <= in_word.center_q;
				pos_r_q <= in_word.center_r - C'(l_nr);
			end else begin
				pos_q_q <= in_word.start_q;
				pos_r_q <= in_word.start_r;
			end
		end else if (cmd.step) begin
			cnt_q <= cnt_q + CW'(1);
			for (int c = 0; c < 3; c++) begin
				k_q[c]   <= k_nx[c];
				rem_q[c] <= rem_nx[c];
			end
			if (mode_q == MODE_RING) begin
				pos_q_q <= pos_q_q + dir_dq;
				pos_r_q <= pos_r_q + dir_dr;
				if (ring_turn) begin
					j_q   <= '0;
					dir_q <= dir_q + 3'd1;
				end else begin
					j_q <= j_q + RADIUS_BITS'(1);
				end
			end else if (pos_q_q != end_q_q) begin
				pos_q_q <= sq_neg_q ? pos_q_q - C'(1) : pos_q_q + C'(1);
			end else begin
				pos_r_q <= sr_neg_q ? pos_r_q - C'(1) : pos_r_q + C'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			out_q.hex_q     <= pt_q;
			out_q.hex_r     <= pt_r;
			out_q.glyph     <= glyph;
			out_q.last      <= stat.last;
			out_q.truncated <= cap && !nat_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= cmd.step || (out_valid_q && out_stall);
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule

`default_nettype wire
